// ===== hw/rtl/rounded_rect_row_span_defines.svh =====
// ----------------------------------------------------------------------------
// rounded_rect_row_span_defines
// Assertion macros shared by the rounded rectangle span checker.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_ROW_SPAN_DEFINES_SVH
`define ROUNDED_RECT_ROW_SPAN_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RRS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RRS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the rounded rectangle row span generator.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int DEF_COORD_BITS = 16;

  // fixed field widths
  localparam int SIZE_W   = 14;
  localparam int RADIUS_W = 12;
  localparam int ROW_W    = 13;
  localparam int CORNER_W = 4;
  localparam int PITCH_W  = 16;
  localparam int BPP_W    = 3;
  localparam int OFFSET_W = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [SIZE_W-1:0] SCREEN_MAX = 14'd8192;

  // register reset values
  localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 14'd1024;
  localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 14'd768;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 16'd4096;
  localparam logic [BPP_W-1:0]   RST_BPP           = 3'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCREEN_WIDTH    = 2'd0,
    REG_SCREEN_HEIGHT   = 2'd1,
    REG_ROW_PITCH       = 2'd2,
    REG_BYTES_PER_PIXEL = 2'd3
  } cfg_reg_t;

  // bit positions in corner_mask
  localparam int CORNER_TL_BIT = 0;
  localparam int CORNER_TR_BIT = 1;
  localparam int CORNER_BL_BIT = 2;
  localparam int CORNER_BR_BIT = 3;

  // integer square root of a 24-bit radicand
  localparam int RAD_W       = 2 * RADIUS_W;
  localparam int ROOT_W      = RADIUS_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_SPS    = 3;
  localparam int SQRT_STAGES = ROOT_W / SQRT_SPS;

  // output word layout
  localparam int OUT_VIS_BIT    = 0;
  localparam int OUT_START_LSB  = 1;
  localparam int OUT_WIDTH_LSB  = OUT_START_LSB + ROW_W;
  localparam int OUT_OFFSET_LSB = OUT_WIDTH_LSB + SIZE_W;
  localparam int OUT_USED_W     = OUT_OFFSET_LSB + OFFSET_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic kill;   // row off screen or outside the rectangle
    logic lbit;   // apply inset on the left
    logic rbit;   // apply inset on the right
  } rrs_flags_t;

endpackage

// ===== hw/rtl/rrs_front.sv =====
// ----------------------------------------------------------------------------
// rrs_front
// Row classification, corner distance and square-root radicand, 3 stages.
// ----------------------------------------------------------------------------
module rrs_front #(
  parameter int COORD_BITS = rrs_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_BITS-1:0]      rect_left,
  input  logic signed [COORD_BITS-1:0]      rect_top,
  input  logic [rrs_pkg::SIZE_W-1:0]        rect_width,
  input  logic [rrs_pkg::SIZE_W-1:0]        rect_height,
  input  logic [rrs_pkg::CORNER_W-1:0]      corner_mask,
  input  logic [rrs_pkg::RADIUS_W-1:0]      radius,
  input  logic [rrs_pkg::ROW_W-1:0]         row_index,
  input  logic [rrs_pkg::SIZE_W-1:0]        screen_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrs_pkg::RAD_W-1:0]         out_rad,
  output logic signed [COORD_BITS-1:0]      out_left,
  output logic [rrs_pkg::SIZE_W-1:0]        out_width,
  output logic [rrs_pkg::RADIUS_W-1:0]      out_radius,
  output logic [rrs_pkg::ROW_W-1:0]         out_srow,
  output rrs_pkg::rrs_flags_t               out_flags
);
  import rrs_pkg::*;

  localparam int AW = ((COORD_BITS > 15) ? COORD_BITS : 15) + 3;
  localparam int NS = 3;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  // stage 1 combinational
  logic signed [AW-1:0] srow_c;
  logic [SIZE_W-1:0]    lower_sum;
  logic [SIZE_W-1:0]    d_lo_full;
  logic                 upper;
  logic                 round_c;
  rrs_flags_t           flags_c;
  logic [RADIUS_W-1:0]  d_c;

  logic signed [COORD_BITS-1:0] s1_left, s2_left, s3_left;
  logic [SIZE_W-1:0]            s1_width, s2_width, s3_width;
  logic [RADIUS_W-1:0]          s1_r, s2_r, s3_r;
  logic [RADIUS_W-1:0]          s1_d;
  logic [ROW_W-1:0]             s1_srow, s2_srow, s3_srow;
  rrs_flags_t                   s1_flags, s2_flags, s3_flags;
  logic [RAD_W-1:0]             s2_rr, s2_dd, s3_rad;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    srow_c = $signed({{(AW-COORD_BITS){rect_top[COORD_BITS-1]}}, rect_top})
           + $signed({{(AW-ROW_W){1'b0}}, row_index});
    lower_sum = {1'b0, row_index} + {2'b0, radius};
    d_lo_full = lower_sum + 14'd1 - rect_height;
    upper     = row_index < {1'b0, radius};
    round_c   = upper || (lower_sum >= rect_height);
    d_c       = upper ? (radius - row_index[RADIUS_W-1:0]) : d_lo_full[RADIUS_W-1:0];
    flags_c.kill = (srow_c < 0)
                || (srow_c >= $signed({{(AW-SIZE_W){1'b0}}, screen_height}))
                || ({1'b0, row_index} >= rect_height);
    flags_c.lbit = round_c && (upper ? corner_mask[CORNER_TL_BIT]
                                     : corner_mask[CORNER_BL_BIT]);
    flags_c.rbit = round_c && (upper ? corner_mask[CORNER_TR_BIT]
                                     : corner_mask[CORNER_BR_BIT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_left  <= rect_left;
      s1_width <= rect_width;
      s1_r     <= radius;
      s1_d     <= d_c;
      s1_srow  <= srow_c[ROW_W-1:0];
      s1_flags <= flags_c;
    end
    // squares of radius and corner distance
    if (rdy[1]) begin
      s2_rr    <= {{RADIUS_W{1'b0}}, s1_r} * {{RADIUS_W{1'b0}}, s1_r};
      s2_dd    <= {{RADIUS_W{1'b0}}, s1_d} * {{RADIUS_W{1'b0}}, s1_d};
      s2_left  <= s1_left;
      s2_width <= s1_width;
      s2_r     <= s1_r;
      s2_srow  <= s1_srow;
      s2_flags <= s1_flags;
    end
    if (rdy[2]) begin
      s3_rad   <= s2_rr - s2_dd;
      s3_left  <= s2_left;
      s3_width <= s2_width;
      s3_r     <= s2_r;
      s3_srow  <= s2_srow;
      s3_flags <= s2_flags;
    end
  end

  assign out_valid  = vld[NS-1];
  assign out_rad    = s3_rad;
  assign out_left   = s3_left;
  assign out_width  = s3_width;
  assign out_radius = s3_r;
  assign out_srow   = s3_srow;
  assign out_flags  = s3_flags;

endmodule

// ===== hw/rtl/rrs_isqrt.sv =====
// ----------------------------------------------------------------------------
// rrs_isqrt
// Pipelined restoring integer square root, a few root bits per stage.
// ----------------------------------------------------------------------------
module rrs_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrs_pkg::RAD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrs_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]           out_side
);
  import rrs_pkg::*;

  localparam int NS = SQRT_STAGES;

  logic [NS-1:0]     vld;
  logic [NS:0]       rdy;
  logic [RAD_W-1:0]  rad_q  [NS];
  logic [ROOT_W-1:0] root_q [NS];
  logic [REM_W-1:0]  rem_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              valid_in;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [SIDE_W-1:0] side_in;
    logic [ROOT_W-1:0] root_next;
    logic [REM_W-1:0]  rem_next;

    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign rad_in   = in_rad;
      assign root_in  = '0;
      assign rem_in   = '0;
      assign side_in  = in_side;
    end else begin : g_rest
      assign valid_in = vld[s-1];
      assign rad_in   = rad_q[s-1];
      assign root_in  = root_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign side_in  = side_q[s-1];
    end

    // one root bit per step, two radicand bits brought down each time
    always_comb begin
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      int               idx;
      root_next = root_in;
      rem_next  = rem_in;
      for (int j = 0; j < SQRT_SPS; j++) begin
        idx    = ROOT_W - 1 - s * SQRT_SPS - j;
        rem_sh = {rem_next, rad_in[2*idx +: 2]};
        trial  = {2'b00, root_next, 2'b01};
        if (rem_sh >= trial) begin
          rem_next  = REM_W'(rem_sh - trial);
          root_next = {root_next[ROOT_W-2:0], 1'b1};
        end else begin
          rem_next  = rem_sh[REM_W-1:0];
          root_next = {root_next[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rad_q[s]  <= rad_in;
        root_q[s] <= root_next;
        rem_q[s]  <= rem_next;
        side_q[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_root  = root_q[NS-1];
  assign out_side  = side_q[NS-1];

endmodule

// ===== hw/rtl/rrs_span.sv =====
// ----------------------------------------------------------------------------
// rrs_span
// Corner inset, screen clipping and byte offset, 6 stages, last one is the
// output register.
// ----------------------------------------------------------------------------
module rrs_span #(
  parameter int COORD_BITS = rrs_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrs_pkg::ROOT_W-1:0]    root,
  input  logic signed [COORD_BITS-1:0]  left,
  input  logic [rrs_pkg::SIZE_W-1:0]    width,
  input  logic [rrs_pkg::RADIUS_W-1:0]  radius,
  input  logic [rrs_pkg::ROW_W-1:0]     srow,
  input  rrs_pkg::rrs_flags_t           flags,
  input  logic [rrs_pkg::SIZE_W-1:0]    screen_width,
  input  logic [rrs_pkg::PITCH_W-1:0]   row_pitch,
  input  logic [rrs_pkg::BPP_W-1:0]     bytes_per_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible,
  output logic [rrs_pkg::ROW_W-1:0]     span_start,
  output logic [rrs_pkg::SIZE_W-1:0]    span_width,
  output logic [rrs_pkg::OFFSET_W-1:0]  byte_offset
);
  import rrs_pkg::*;

  localparam int AW    = ((COORD_BITS > 15) ? COORD_BITS : 15) + 3;
  localparam int NS    = 6;
  localparam int PX_W  = ROW_W + BPP_W;
  localparam int PY_W  = ROW_W + PITCH_W;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  // stage a
  logic [RADIUS_W-1:0]          a_inset;
  logic signed [COORD_BITS-1:0] a_left;
  logic [SIZE_W-1:0]            a_width;
  logic [ROW_W-1:0]             a_srow;
  rrs_flags_t                   a_flags;
  // stage b
  logic signed [AW-1:0]         b_x, b_w;
  logic [ROW_W-1:0]             b_srow;
  logic                         b_kill;
  // stage c
  logic signed [AW-1:0]         c_x, c_w;
  logic [ROW_W-1:0]             c_srow;
  logic                         c_kill;
  // stage d
  logic                         d_vis;
  logic [ROW_W-1:0]             d_x;
  logic [SIZE_W-1:0]            d_w;
  logic [ROW_W-1:0]             d_srow;
  // stage e
  logic                         e_vis;
  logic [ROW_W-1:0]             e_x;
  logic [SIZE_W-1:0]            e_w;
  logic [PX_W-1:0]              e_px;
  logic [PY_W-1:0]              e_py;

  logic [RADIUS_W-1:0]  ins_l, ins_r;
  logic signed [AW-1:0] sw_ext;
  logic signed [AW-1:0] d_sum;
  logic                 d_over;
  logic signed [AW-1:0] d_wf;
  logic                 d_vis_c;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    ins_l  = a_flags.lbit ? a_inset : '0;
    ins_r  = a_flags.rbit ? a_inset : '0;
    sw_ext = $signed({{(AW-SIZE_W){1'b0}}, screen_width});
    // right clip: past the screen edge the width is cut to the edge
    d_sum  = c_x + c_w;
    d_over = d_sum > sw_ext;
    d_wf   = d_over ? (sw_ext - c_x) : c_w;
    d_vis_c = !c_kill && (d_over ? (c_x < sw_ext) : (c_w > 0));
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_inset <= radius - root;
      a_left  <= left;
      a_width <= width;
      a_srow  <= srow;
      a_flags <= flags;
    end
    if (rdy[1]) begin
      b_x <= $signed({{(AW-COORD_BITS){a_left[COORD_BITS-1]}}, a_left})
           + $signed({{(AW-RADIUS_W){1'b0}}, ins_l});
      b_w <= $signed({{(AW-SIZE_W){1'b0}}, a_width})
           - $signed({{(AW-RADIUS_W){1'b0}}, ins_l})
           - $signed({{(AW-RADIUS_W){1'b0}}, ins_r});
      b_srow <= a_srow;
      b_kill <= a_flags.kill;
    end
    // left clip
    if (rdy[2]) begin
      if (b_x < 0) begin
        c_x <= '0;
        c_w <= b_w + b_x;
      end else begin
        c_x <= b_x;
        c_w <= b_w;
      end
      c_srow <= b_srow;
      c_kill <= b_kill;
    end
    if (rdy[3]) begin
      d_vis  <= d_vis_c;
      d_x    <= c_x[ROW_W-1:0];
      d_w    <= d_wf[SIZE_W-1:0];
      d_srow <= c_srow;
    end
    if (rdy[4]) begin
      e_vis <= d_vis;
      e_x   <= d_x;
      e_w   <= d_w;
      e_px  <= {{BPP_W{1'b0}}, d_x} * {{ROW_W{1'b0}}, bytes_per_pixel};
      e_py  <= {{PITCH_W{1'b0}}, d_srow} * {{ROW_W{1'b0}}, row_pitch};
    end
    if (rdy[5]) begin
      visible     <= e_vis;
      span_start  <= e_vis ? e_x : '0;
      span_width  <= e_vis ? e_w : '0;
      byte_offset <= e_vis ? (OFFSET_W'(e_px) + OFFSET_W'(e_py)) : '0;
    end
  end

  assign out_valid = vld[NS-1];

endmodule

// ===== hw/rtl/rounded_rect_row_span.sv =====
// Throughput: one word per cycle while the output side does not stall; the path
//   is the 3-stage front, the 4-stage square root (3 root bits per stage) and
//   the 6-stage span/offset section.
// Reset (synchronous) empties the pipeline and loads the registers with
//   screen 1024 x 768, pitch 4096 and 4 bytes per pixel.
// ----------------------------------------------------------------------------
// rounded_rect_row_span
// Clipped span and framebuffer byte offset for one row of a rounded rectangle.
// ----------------------------------------------------------------------------
module rounded_rect_row_span #(
  parameter int COORD_BITS = rrs_pkg::DEF_COORD_BITS,
  localparam int IN_USED_W = 2 * COORD_BITS + 2 * rrs_pkg::SIZE_W + rrs_pkg::CORNER_W
                           + rrs_pkg::RADIUS_W + rrs_pkg::ROW_W,
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // rect_left, rect_top, rect_width, rect_height, corner_mask, radius,
  // row_index (lowest bit up)
  input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // visible, span_start, span_width, byte_offset (lowest bit up)
  output logic [rrs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we,
  input  logic [rrs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rrs_pkg::CFG_W-1:0]           cfg_wdata
);
  import rrs_pkg::*;

  localparam int TOP_LSB    = COORD_BITS;
  localparam int WIDTH_LSB  = 2 * COORD_BITS;
  localparam int HEIGHT_LSB = WIDTH_LSB + SIZE_W;
  localparam int CORNER_LSB = HEIGHT_LSB + SIZE_W;
  localparam int RADIUS_LSB = CORNER_LSB + CORNER_W;
  localparam int ROW_LSB    = RADIUS_LSB + RADIUS_W;
  localparam int SIDE_W     = COORD_BITS + SIZE_W + RADIUS_W + ROW_W + $bits(rrs_flags_t);

  // registers hold the clamped screen size
  logic [SIZE_W-1:0]  screen_width;
  logic [SIZE_W-1:0]  screen_height;
  logic [PITCH_W-1:0] row_pitch;
  logic [BPP_W-1:0]   bytes_per_pixel;
  logic [SIZE_W-1:0]  cfg_size;
  logic [SIZE_W-1:0]  cfg_size_lim;

  logic                         fr_valid, fr_ready;
  logic [RAD_W-1:0]             fr_rad;
  logic signed [COORD_BITS-1:0] fr_left;
  logic [SIZE_W-1:0]            fr_width;
  logic [RADIUS_W-1:0]          fr_radius;
  logic [ROW_W-1:0]             fr_srow;
  rrs_flags_t                   fr_flags;

  logic                         sq_valid, sq_ready;
  logic [ROOT_W-1:0]            sq_root;
  logic [SIDE_W-1:0]            sq_side;

  logic signed [COORD_BITS-1:0] sp_left;
  logic [SIZE_W-1:0]            sp_width;
  logic [RADIUS_W-1:0]          sp_radius;
  logic [ROW_W-1:0]             sp_srow;
  rrs_flags_t                   sp_flags;

  logic                         visible;
  logic [ROW_W-1:0]             span_start;
  logic [SIZE_W-1:0]            span_width;
  logic [OFFSET_W-1:0]          byte_offset;

  assign cfg_size     = cfg_wdata[SIZE_W-1:0];
  assign cfg_size_lim = (cfg_size > SCREEN_MAX) ? SCREEN_MAX : cfg_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width    <= RST_SCREEN_WIDTH;
      screen_height   <= RST_SCREEN_HEIGHT;
      row_pitch       <= RST_ROW_PITCH;
      bytes_per_pixel <= RST_BPP;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCREEN_WIDTH:    screen_width    <= cfg_size_lim;
        REG_SCREEN_HEIGHT:   screen_height   <= cfg_size_lim;
        REG_ROW_PITCH:       row_pitch       <= cfg_wdata[PITCH_W-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_wdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  rrs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .rect_left     (s_axis_tdata[COORD_BITS-1:0]),
    .rect_top      (s_axis_tdata[TOP_LSB +: COORD_BITS]),
    .rect_width    (s_axis_tdata[WIDTH_LSB +: SIZE_W]),
    .rect_height   (s_axis_tdata[HEIGHT_LSB +: SIZE_W]),
    .corner_mask   (s_axis_tdata[CORNER_LSB +: CORNER_W]),
    .radius        (s_axis_tdata[RADIUS_LSB +: RADIUS_W]),
    .row_index     (s_axis_tdata[ROW_LSB +: ROW_W]),
    .screen_height (screen_height),
    .out_valid     (fr_valid),
    .out_ready     (fr_ready),
    .out_rad       (fr_rad),
    .out_left      (fr_left),
    .out_width     (fr_width),
    .out_radius    (fr_radius),
    .out_srow      (fr_srow),
    .out_flags     (fr_flags)
  );

  rrs_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_side   ({fr_flags, fr_srow, fr_radius, fr_width, fr_left}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign {sp_flags, sp_srow, sp_radius, sp_width, sp_left} = sq_side;

  rrs_span #(.COORD_BITS(COORD_BITS)) u_span (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (sq_valid),
    .in_ready        (sq_ready),
    .root            (sq_root),
    .left            (sp_left),
    .width           (sp_width),
    .radius          (sp_radius),
    .srow            (sp_srow),
    .flags           (sp_flags),
    .screen_width    (screen_width),
    .row_pitch       (row_pitch),
    .bytes_per_pixel (bytes_per_pixel),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .visible         (visible),
    .span_start      (span_start),
    .span_width      (span_width),
    .byte_offset     (byte_offset)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                         byte_offset, span_width, span_start, visible};

endmodule

// ===== hw/rtl/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the rounded rectangle row span generator.
// ----------------------------------------------------------------------------
`include "rounded_rect_row_span_defines.svh"

module rrs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rrs_pkg::*;

  logic               vis;
  logic [ROW_W-1:0]   start;
  logic [SIZE_W-1:0]  wid;
  logic [SIZE_W:0]    span_end;

  assign vis      = m_axis_tdata[OUT_VIS_BIT];
  assign start    = m_axis_tdata[OUT_START_LSB +: ROW_W];
  assign wid      = m_axis_tdata[OUT_WIDTH_LSB +: SIZE_W];
  assign span_end = {2'b00, start} + {1'b0, wid};

  // a stalled result word holds
  `RRS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // pipeline comes out of reset empty and ready
  `RRS_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst),
    !m_axis_tvalid && s_axis_tready, "pipeline not empty after reset")

  // hidden rows carry all-zero fields
  `RRS_ASSERT_NOW(a_hidden_zero, clk, rst, m_axis_tvalid && !vis,
    m_axis_tdata[OUT_TDATA_W-1:1] == '0, "hidden row with nonzero fields")

  // a visible span is non-empty and ends within the largest screen size
  `RRS_ASSERT_NOW(a_span_fits, clk, rst, m_axis_tvalid && vis,
    (wid != '0) && (span_end <= {1'b0, SCREEN_MAX}), "visible span empty or off screen")

endmodule

bind rounded_rect_row_span rrs_checker u_rrs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_rounded_rect_row_span.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rounded_rect_row_span
// Drives row requests into the rounded rectangle span block and checks every
// result word against an in-bench span predictor. Both stream sides stall at
// random, but for the largest-geometry phase. Screen geometry is reprogrammed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_rounded_rect_row_span;
  import rrs_pkg::*;

  localparam int COORD_BITS  = 16;
  localparam int IN_W        = 96;
  localparam int OUT_W       = OUT_TDATA_W;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  // one request word, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [12:0]        row_index;
    logic [11:0]        radius;
    logic [3:0]         corner_mask;
    logic [13:0]        rect_height;
    logic [13:0]        rect_width;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_left;
  } row_req_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] byte_offset;
    logic [13:0] span_width;
    logic [12:0] span_start;
    logic        visible;
  } span_res_t;

  class row_span_scoreboard;
    logic [13:0] scr_w;
    logic [13:0] scr_h;
    logic [15:0] pitch;
    logic [2:0]  bpp;
    span_res_t   span_q[$];
    int          fail_count;

    function new();
      scr_w      = RST_SCREEN_WIDTH;
      scr_h      = RST_SCREEN_HEIGHT;
      pitch      = RST_ROW_PITCH;
      bpp        = RST_BPP;
      fail_count = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_SCREEN_WIDTH: scr_w = v[13:0];
        REG_SCREEN_HEIGHT: scr_h = v[13:0];
        REG_ROW_PITCH: pitch = v;
        REG_BYTES_PER_PIXEL: bpp = v[2:0];
        default: ;
      endcase
    endfunction

    // largest root whose square fits, built one bit at a time
    function int unsigned floor_sqrt(int unsigned n);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 11; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function void note_row(row_req_t q);
      longint x, w, h, r, row, srow, sw, sh, d, inset, offs;
      bit upper, lft, rgt;
      span_res_t res;
      res  = '0;
      x    = longint'($signed(q.rect_left));
      w    = q.rect_width;
      h    = q.rect_height;
      r    = q.radius;
      row  = q.row_index;
      srow = longint'($signed(q.rect_top)) + row;
      sw   = (scr_w > SCREEN_MAX) ? SCREEN_MAX : scr_w;
      sh   = (scr_h > SCREEN_MAX) ? SCREEN_MAX : scr_h;
      if (!(srow < 0 || srow >= sh || row >= h)) begin
        // top corner zone wins when the row sits in both
        if (row < r || row >= h - r) begin
          upper = row < r;
          d     = upper ? (r - row) : (row + r - h + 1);
          inset = r - longint'(floor_sqrt(r * r - d * d));
          lft   = upper ? q.corner_mask[CORNER_TL_BIT]
                        : q.corner_mask[CORNER_BL_BIT];
          rgt   = upper ? q.corner_mask[CORNER_TR_BIT]
                        : q.corner_mask[CORNER_BR_BIT];
          if (lft) begin
            x += inset;
            w -= inset;
          end
          if (rgt) w -= inset;
        end
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (x + w > sw) w = sw - x;
        if (w > 0) begin
          offs            = x * longint'(bpp) + srow * longint'(pitch);
          res.visible     = 1'b1;
          res.span_start  = x[12:0];
          res.span_width  = w[13:0];
          res.byte_offset = offs[31:0];
        end
      end
      span_q.push_back(res);
    endfunction

    function void check_span(span_res_t got);
      span_res_t want;
      if (span_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("span word %h arrived with no row pending", got);
        return;
      end
      want = span_q.pop_front();
      if (got.visible !== want.visible || got.span_start !== want.span_start ||
          got.span_width !== want.span_width || got.byte_offset !== want.byte_offset) begin
        fail_count++;
        if (fail_count <= 10)
          $display("span mismatch: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                   want.visible, want.span_start, want.span_width, want.byte_offset,
                   got.visible, got.span_start, got.span_width, got.byte_offset);
      end
    endfunction

    function int outstanding();
      return span_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  // rect_left, rect_top, rect_width, rect_height, corner_mask, radius,
  // row_index (lowest bit up)
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // visible, span_start, span_width, byte_offset (lowest bit up)
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  row_span_scoreboard sb;
  bit src_idle_en;
  bit snk_idle_en;
  int stall_cycles = 0;

  rounded_rect_row_span #(.COORD_BITS(COORD_BITS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= !(snk_idle_en && $urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_span(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_rounded_rect_row_span: FAIL");
        $finish;
      end
    end
  end

  function automatic row_req_t mk_row(int left, int top, int wd, int ht, int corners,
                                      int rad, int row);
    row_req_t q;
    q             = '0;
    q.rect_left   = left[15:0];
    q.rect_top    = top[15:0];
    q.rect_width  = wd[13:0];
    q.rect_height = ht[13:0];
    q.corner_mask = corners[3:0];
    q.radius      = rad[11:0];
    q.row_index   = row[12:0];
    return q;
  endfunction

  // mostly small rectangles placed near the screen, rows biased to the corners
  function automatic row_req_t rand_row();
    row_req_t q;
    int sw, sh, wd, ht, lim, rad, row, srow;
    if ($urandom_range(99) < 25) begin
      q     = {$urandom(), $urandom(), $urandom()};
      q.pad = '0;
      return q;
    end
    sw = (sb.scr_w > SCREEN_MAX) ? SCREEN_MAX : sb.scr_w;
    sh = (sb.scr_h > SCREEN_MAX) ? SCREEN_MAX : sb.scr_h;
    if (sw == 0) sw = 1;
    if (sh == 0) sh = 1;
    wd  = ($urandom_range(19) == 0) ? $urandom_range(0, 8192) : $urandom_range(0, 80);
    ht  = ($urandom_range(19) == 0) ? $urandom_range(0, 8192) : $urandom_range(0, 80);
    lim = ((wd < ht) ? wd : ht) / 2 + 2;
    rad = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, lim);
    if (rad > 4095) rad = 4095;
    row = $urandom_range(0, ht + 2);
    if (rad > 0 && $urandom_range(1) == 1) begin
      if ($urandom_range(1) == 1) row = $urandom_range(0, rad - 1);
      else row = ht - 1 - int'($urandom_range(0, rad - 1));
    end
    if (row < 0) row = 0;
    if (row > 8191) row = 8191;
    srow = int'($urandom_range(0, sh + 8)) - 4;
    return mk_row(int'($urandom_range(0, wd + sw + 16)) - wd - 8, srow - row, wd, ht,
                  $urandom_range(15), rad, row);
  endfunction

  task automatic push_row(row_req_t q);
    s_axis_tdata  <= q;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_row(q);
    @(negedge clk);
    if (src_idle_en && $urandom_range(99) < 3) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_screen(logic [15:0] w, logic [15:0] h, logic [15:0] p,
                                logic [15:0] b);
    cfg_reg_t    regs[4] = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_ROW_PITCH,
                             REG_BYTES_PER_PIXEL};
    logic [15:0] vals[4];
    vals = '{w, h, p, b};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) settle_pipeline();
      push_row(rand_row());
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_SCREEN_WIDTH;
    cfg_wdata     = '0;
    src_idle_en   = 1'b1;
    snk_idle_en   = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows at the reset geometry, 1024 x 768
    push_row(mk_row(0, 0, 100, 50, 0, 0, 0));
    push_row(mk_row(-32768, -32768, 100, 50, 15, 5, 0));
    push_row(mk_row(32767, 32767, 100, 50, 15, 5, 0));
    push_row(mk_row(0, 767, 16383, 16383, 0, 0, 0));
    push_row(mk_row(10, 10, 100, 0, 0, 0, 0));
    push_row(mk_row(-100, -8000, 8192, 8192, 15, 0, 8191));
    push_row(mk_row(-3500, 0, 8192, 8192, 15, 4095, 0));
    push_row(mk_row(100, 100, 40, 40, 1, 10, 2));
    push_row(mk_row(100, 100, 40, 40, 2, 10, 2));
    push_row(mk_row(100, 100, 40, 40, 4, 10, 37));
    push_row(mk_row(100, 100, 40, 40, 8, 10, 37));
    // row inside both corner zones
    push_row(mk_row(200, 200, 60, 6, 15, 10, 2));
    // inset wider than the rectangle
    push_row(mk_row(200, 200, 5, 30, 3, 20, 0));
    // bottom zone with only top corners rounded
    push_row(mk_row(50, 50, 30, 30, 3, 8, 28));
    push_row(mk_row(50, 50, 30, 30, 12, 8, 22));
    push_row(mk_row(-30, 5, 50, 10, 0, 0, 3));
    push_row(mk_row(1000, 5, 24, 10, 0, 0, 3));
    push_row(mk_row(1024, 5, 24, 10, 0, 0, 3));
    push_row(mk_row(10, 5, 0, 10, 0, 0, 3));
    push_row(mk_row(10, -1, 20, 10, 0, 0, 0));
    push_row(mk_row(10, 768, 20, 10, 0, 0, 0));
    push_row(mk_row(10, 10, 20, 10, 15, 1, 0));

    run_random(300, 1'b1);
    settle_pipeline();

    // largest geometry, offsets still fit in 32 bits; no stalls on either side
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    program_screen(16'd8192, 16'd8192, 16'd65535, 16'd7);
    run_random(250, 1'b0);
    settle_pipeline();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    program_screen(16'd1, 16'd1, 16'd1, 16'd0);
    run_random(150, 1'b0);
    settle_pipeline();

    // oversized screen registers clamp, upper write bits are dropped
    program_screen(16'hFFFF, 16'd9000, 16'd12345, 16'd5);
    run_random(250, 1'b0);
    settle_pipeline();

    program_screen(16'd0, 16'd480, 16'd640, 16'd6);
    run_random(100, 1'b0);
    settle_pipeline();

    program_screen(16'd640, 16'd480, 16'd1280, 16'd2);
    run_random(300, 1'b0);
    settle_pipeline();

    repeat (3) begin
      program_screen(16'($urandom_range(1, 8192)), 16'($urandom_range(1, 8192)),
                     16'($urandom_range(1, 65535)), 16'($urandom_range(0, 7)));
      run_random(200, 1'b0);
      settle_pipeline();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("tb_rounded_rect_row_span: PASS");
    end else begin
      $display("tb_rounded_rect_row_span: FAIL");
    end
    $finish;
  end

endmodule
